>>> src/fsr_pkg.sv
// ----------------------------------------------------------------------------
// Framed serial receiver package
// Transaction payload types, codes and the configuration bundle shared by the
// receiver modules and its channel interfaces.
// ----------------------------------------------------------------------------
package fsr_pkg;

   // Width of the configuration write data and of the register index.
   localparam int CsrDataWidth  = 32;
   localparam int CsrIndexWidth = 2;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] RegPayloadLen   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] RegFormatWord   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] RegTimeoutTicks = 2'd2;

   // Event codes carried in the action field.
   localparam logic [1:0] ActByte    = 2'd0;
   localparam logic [1:0] ActTick    = 2'd1;
   localparam logic [1:0] ActTrigger = 2'd2;
   localparam logic [1:0] ActAck     = 2'd3;

   // Status codes.
   localparam logic [2:0] StIdle0   = 3'd0;
   localparam logic [2:0] StIdle1   = 3'd1;
   localparam logic [2:0] StActive0 = 3'd2;
   localparam logic [2:0] StActive1 = 3'd3;
   localparam logic [2:0] StReady   = 3'd4;

   // One input transaction: an event code and the received byte.
   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
   } req_payload_type;

   // One result transaction.
   typedef struct packed {
      logic [2:0]  status;
      logic        write_valid;
      logic [15:0] write_index;
      logic [7:0]  write_byte;
      logic        frame_release;
      logic        id_valid;
      logic [7:0]  id_value;
      logic        response_due;
   } rsp_payload_type;

   // Configuration registers as seen by the frame engine.
   typedef struct packed {
      logic [15:0] payload_len;
      logic [31:0] format_word;
      logic [15:0] timeout_ticks;
   } cfg_type;

endpackage

>>> src/fsr_if.sv
// ----------------------------------------------------------------------------
// Framed serial receiver channels
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface fsr_req_if;
   logic                     valid;
   logic                     ready;
   fsr_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fsr_rsp_if;
   logic                     valid;
   logic                     ready;
   fsr_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/framed_serial_receiver.sv
// ----------------------------------------------------------------------------
// Framed serial receiver
// Checks framed serial input: header rules, payload writes, CRC-32 trailer.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one event per transaction: a received byte, a time tick,
//   a processing trigger or a query acknowledge. rsp_chan returns exactly one
//   result transaction per event with the status code and any payload write,
//   frame release, new id or response request it caused.
//   The csr_ port writes payload length, format word and phase timeout; write
//   it only while no event is in flight.
// Result path and throughput:
//   A result is valid on rsp_chan once its event has passed the input
//   register and the frame engine has worked on it; the result register
//   loads when the engine takes the event from the input register.
//   One event is accepted every cycle while the receiver of rsp_chan keeps
//   up; the byte-wide CRC update and the header compare sit between those two registers.
// Reset and stalls:
//   Reset clears the frame state to the header search with idle0 status and
//   loads the default configuration. When the receiver of rsp_chan stalls,
//   the result register holds, the input register fills, and req_chan.ready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
module framed_serial_receiver #(
   parameter int MAX_PAYLOAD_BYTES = 65535
) (
   input  logic                               clock,
   input  logic                               reset,
   fsr_req_if.sink                            req_chan,
   fsr_rsp_if.source                          rsp_chan,
   input  logic                               csr_write,
   input  logic [fsr_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [fsr_pkg::CsrDataWidth-1:0]   csr_data
);
   import fsr_pkg::*;

   cfg_type         cfg;
   logic            item_valid;
   req_payload_type item;
   logic            take;

   fsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fsr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   fsr_engine #(
      .MaxLen (16'(MAX_PAYLOAD_BYTES))
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> src/fsr_csr.sv
// ----------------------------------------------------------------------------
// Framed serial receiver configuration registers
// Holds payload length, expected format word and phase timeout.
// ----------------------------------------------------------------------------
module fsr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [fsr_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [fsr_pkg::CsrDataWidth-1:0]   csr_data,
   output fsr_pkg::cfg_type                   cfg
);
   import fsr_pkg::*;

   localparam logic [15:0] ResetPayloadLen   = 16'd1024;
   localparam logic [31:0] ResetFormatWord   = 32'h0000_0000;
   localparam logic [15:0] ResetTimeoutTicks = 16'd1000;

   cfg_type cfg_ff;

   // Register writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.payload_len   <= ResetPayloadLen;
         cfg_ff.format_word   <= ResetFormatWord;
         cfg_ff.timeout_ticks <= ResetTimeoutTicks;
      end else if (csr_write) begin
         case (csr_index)
            RegPayloadLen:   cfg_ff.payload_len   <= csr_data[15:0];
            RegFormatWord:   cfg_ff.format_word   <= csr_data[31:0];
            RegTimeoutTicks: cfg_ff.timeout_ticks <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/fsr_in_stage.sv
// ----------------------------------------------------------------------------
// Framed serial receiver input register
// Captures one request transaction and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module fsr_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   fsr_req_if.sink                  req_chan,
   input  logic                     take,
   output logic                     item_valid,
   output fsr_pkg::req_payload_type item
);
   import fsr_pkg::*;

   logic            valid_ff;
   req_payload_type item_ff;

   // The slot is free when empty or when its item moves on this cycle.
   assign req_chan.ready = !valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload capture needs no reset.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff <= req_chan.payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> src/fsr_engine.sv
// ----------------------------------------------------------------------------
// Framed serial receiver frame engine
// Frame state machine, header match, CRC-32 update, trailer check and the
// result register.
// ----------------------------------------------------------------------------
module fsr_engine #(
   parameter logic [15:0] MaxLen = 16'd65535
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fsr_pkg::cfg_type         cfg,
   input  logic                     item_valid,
   input  fsr_pkg::req_payload_type item,
   output logic                     take,
   fsr_rsp_if.source                rsp_chan
);
   import fsr_pkg::*;

   // Command kinds.
   localparam logic [1:0] CmdData  = 2'd0;
   localparam logic [1:0] CmdRaw   = 2'd1;
   localparam logic [1:0] CmdSetId = 2'd2;
   localparam logic [1:0] CmdQuery = 2'd3;

   // Frame constants.
   localparam logic [31:0] Preamble  = 32'hAAEE_AAEE;
   localparam logic [31:0] Delimiter = 32'hAEAE_AEAE;
   localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
   localparam logic [7:0]  ChD = 8'h64;
   localparam logic [7:0]  ChR = 8'h72;
   localparam logic [7:0]  ChI = 8'h69;
   localparam logic [7:0]  ChC = 8'h63;
   localparam logic [7:0]  ChT = 8'h74;
   localparam logic [7:0]  ChQ = 8'h71;
   localparam int          HeaderBytes = 12;

   typedef enum logic [4:0] {
      PH_HEADER   = 5'b00001,
      PH_PAYLOAD  = 5'b00010,
      PH_TRAILER  = 5'b00100,
      PH_READY    = 5'b01000,
      PH_RESPONSE = 5'b10000
   } phase_type;

   // Reflected CRC-32, one byte.
   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         x = (x >> 1) ^ (x[0] ? CrcPoly : 32'd0);
      end
      return x;
   endfunction

   phase_type       phase_ff, phase_in;
   logic [1:0]      cmd_ff, cmd_in;
   logic [15:0]     count_ff, count_in;
   logic [31:0]     crc_ff, crc_in;
   logic [7:0]      hdr_ff [HeaderBytes];
   logic [7:0]      hdr_in [HeaderBytes];
   logic [63:0]     trl_ff, trl_in;
   logic [7:0]      id_ff, id_in;
   logic            parity_ff, parity_in;
   logic [15:0]     timer_ff, timer_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic [7:0]  view [HeaderBytes];
   logic [15:0] eff_len;
   logic [15:0] len_field;
   logic [31:0] fmt_field;
   logic        preamble_ok;
   logic        fmt_len_ok;
   logic        ok_sum;
   logic        go_setup;
   logic [15:0] timer_inc;
   logic [16:0] count_next;

   // The engine takes an item when the result register can accept one.
   assign take = item_valid && (!rsp_valid_ff || rsp_chan.ready);

   assign eff_len = (cfg.payload_len > MaxLen) ? MaxLen : cfg.payload_len;

   // Header as it stands once the current byte is the last one.
   always_comb begin
      for (int i = 0; i < HeaderBytes - 1; i++) begin
         view[i] = hdr_ff[i];
      end
      view[HeaderBytes-1] = item.rx_byte;
   end

   assign len_field   = {view[6], view[7]};
   assign fmt_field   = {view[8], view[9], view[10], view[11]};
   assign preamble_ok = ({view[0], view[1], view[2], view[3]} == Preamble);
   assign fmt_len_ok  = (len_field == eff_len) && (fmt_field == cfg.format_word);
   assign count_next  = {1'b0, count_ff} + 17'd1;
   assign timer_inc   = (timer_ff != 16'hFFFF) ? timer_ff + 16'd1 : timer_ff;

   // Next state and result for the current item.
   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      hdr_in    = hdr_ff;
      trl_in    = trl_ff;
      id_in     = id_ff;
      parity_in = parity_ff;
      timer_in  = timer_ff;
      rsp_in    = '0;
      go_setup  = 1'b0;
      ok_sum    = 1'b0;

      case (item.action)
         ActByte: begin
            case (phase_ff)
               PH_HEADER: begin
                  if (count_ff < 16'(HeaderBytes)) begin
                     hdr_in[count_ff[3:0]] = item.rx_byte;
                     crc_in   = crc_step(crc_ff, item.rx_byte);
                     count_in = count_next[15:0];
                     if (count_ff == 16'(HeaderBytes - 1) && preamble_ok) begin
                        if (view[4] == ChD && view[5] == ChD && fmt_len_ok) begin
                           cmd_in   = CmdData;
                           count_in = '0;
                           phase_in = (eff_len == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
                           timer_in = '0;
                        end else if (view[4] == ChR && view[5] == ChR && fmt_len_ok) begin
                           cmd_in   = CmdRaw;
                           count_in = '0;
                           phase_in = (eff_len == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
                           timer_in = '0;
                        end else if (view[4] == ChI && view[5] == ChC &&
                                     len_field == 16'd1) begin
                           cmd_in   = CmdSetId;
                           count_in = '0;
                           phase_in = PH_PAYLOAD;
                           timer_in = '0;
                        end else if (view[4] == ChT && view[5] == ChQ) begin
                           cmd_in   = CmdQuery;
                           count_in = '0;
                           phase_in = PH_TRAILER;
                           timer_in = '0;
                        end
                     end
                  end
               end
               PH_PAYLOAD: begin
                  if (cmd_ff == CmdSetId) begin
                     id_in    = item.rx_byte;
                     crc_in   = crc_step(crc_ff, item.rx_byte);
                     count_in = '0;
                     phase_in = PH_TRAILER;
                     timer_in = '0;
                  end else if (cmd_ff == CmdQuery) begin
                     count_in = '0;
                     phase_in = PH_TRAILER;
                     timer_in = '0;
                  end else begin
                     rsp_in.write_valid = 1'b1;
                     rsp_in.write_index = count_ff;
                     rsp_in.write_byte  = item.rx_byte;
                     if (cmd_ff == CmdData) begin
                        crc_in = crc_step(crc_ff, item.rx_byte);
                     end
                     if (count_next >= {1'b0, eff_len}) begin
                        count_in = '0;
                        phase_in = PH_TRAILER;
                        timer_in = '0;
                     end else begin
                        count_in = count_next[15:0];
                     end
                  end
               end
               PH_TRAILER: begin
                  trl_in   = {trl_ff[55:0], item.rx_byte};
                  count_in = count_next[15:0];
                  if (count_next >= 17'd8) begin
                     count_in = '0;
                     ok_sum   = (trl_in[63:32] == ~crc_ff);
                     if (trl_in[31:0] == Delimiter) begin
                        if (cmd_ff == CmdRaw || (cmd_ff == CmdData && ok_sum)) begin
                           phase_in = PH_READY;
                           timer_in = '0;
                        end else if (cmd_ff == CmdSetId && ok_sum) begin
                           rsp_in.id_valid = 1'b1;
                           rsp_in.id_value = id_ff;
                           parity_in       = ~parity_ff;
                           go_setup        = 1'b1;
                        end else if (cmd_ff == CmdQuery && ok_sum) begin
                           rsp_in.response_due = 1'b1;
                           phase_in            = PH_RESPONSE;
                           timer_in            = '0;
                        end
                     end
                  end
               end
               PH_READY, PH_RESPONSE: begin
                  // Bytes are dropped while a frame waits.
               end
               default: go_setup = 1'b1;
            endcase
         end
         ActTick: begin
            timer_in = timer_inc;
            if (timer_inc >= cfg.timeout_ticks) begin
               go_setup = 1'b1;
            end
         end
         ActTrigger: begin
            if (phase_ff == PH_READY) begin
               rsp_in.frame_release = 1'b1;
               parity_in            = ~parity_ff;
               go_setup             = 1'b1;
            end
         end
         ActAck: begin
            if (phase_ff == PH_RESPONSE) begin
               parity_in = ~parity_ff;
               go_setup  = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Setup restarts the header search.
      if (go_setup) begin
         count_in = '0;
         crc_in   = '1;
         phase_in = PH_HEADER;
         timer_in = '0;
      end

      case (phase_in)
         PH_PAYLOAD:              rsp_in.status = StActive0;
         PH_TRAILER:              rsp_in.status = StActive1;
         PH_READY, PH_RESPONSE:   rsp_in.status = StReady;
         default:                 rsp_in.status = parity_in ? StIdle1 : StIdle0;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         cmd_ff       <= CmdData;
         count_ff     <= '0;
         crc_ff       <= '1;
         id_ff        <= '0;
         parity_ff    <= 1'b0;
         timer_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff  <= phase_in;
            cmd_ff    <= cmd_in;
            count_ff  <= count_in;
            crc_ff    <= crc_in;
            id_ff     <= id_in;
            parity_ff <= parity_in;
            timer_ff  <= timer_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Header, trailer and result payload registers.
   always_ff @(posedge clock) begin
      if (take) begin
         hdr_ff <= hdr_in;
         trl_ff <= trl_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // A payload write leaves the frame in payload or trailer.
   a_write_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.write_valid |->
         (rsp_ff.status == StActive0 || rsp_ff.status == StActive1))
      else $error("payload write outside an active phase");

   // A completed set-id or a released frame returns to an idle status.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.id_valid || rsp_ff.frame_release) |->
         (rsp_ff.status == StIdle0 || rsp_ff.status == StIdle1))
      else $error("frame completion without idle status");

   // A due response leaves the frame waiting.
   a_response_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.response_due |-> rsp_ff.status == StReady)
      else $error("response due without ready status");

   // At most one event flag per result.
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_ff.write_valid, rsp_ff.frame_release,
                                  rsp_ff.id_valid, rsp_ff.response_due}))
      else $error("more than one event in one result");

endmodule
